// ----- hw/rtl/psn_pkg.sv -----
package psn_pkg;

    typedef enum logic [1:0] {
        WHERE_INSIDE = 2'd0,
        WHERE_START  = 2'd1,
        WHERE_END    = 2'd2,
        WHERE_DEGEN  = 2'd3
    } t_where;

    localparam int unsigned WHERE_W = 2;

endpackage

// ----- hw/rtl/point_segment_nearest.sv -----
// Channel   Valid      Ready      Payload
// input     i_valid    o_ready    i_query_x/y, i_start_x/y, i_end_x/y
// output    o_valid    i_ready    o_disp_x/y, o_foot_x/y, o_where_code
//
// One transaction is accepted per cycle when nothing is stalled, and each
// then passes through the front, multiplier, divider and output stages.
// Reset is synchronous and active low and clears only the valid bits.
// Each stage holds while the stage after it is full and stalled, so empty
// stages keep filling behind a stalled output.
module point_segment_nearest #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_query_x,
    input  logic signed [COORD_WIDTH-1:0] i_query_y,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [COORD_WIDTH:0]   o_disp_x,
    output logic signed [COORD_WIDTH:0]   o_disp_y,
    output logic signed [COORD_WIDTH-1:0] o_foot_x,
    output logic signed [COORD_WIDTH-1:0] o_foot_y,
    output logic [1:0]                    o_where_code
);

    localparam int W      = COORD_WIDTH;
    localparam int SIDE_D = 6 * W + psn_pkg::WHERE_W + 2;
    localparam int SIDE_M = SIDE_D + 2 * W + 1;

    logic              fr_valid, fr_ready;
    logic [6*W-1:0]    fr_pts;
    psn_pkg::t_where   fr_code;
    logic              fr_sx, fr_sy;
    logic [W-1:0]      fr_mx, fr_my;
    logic [2*W:0]      fr_num, fr_den;

    logic              mu_valid, mu_ready;
    logic [3*W:0]      mu_nx, mu_ny;
    logic [SIDE_M-1:0] mu_side;

    logic              dv_valid, dv_ready;
    logic [W-1:0]      dv_qx, dv_qy;
    logic [SIDE_D-1:0] dv_side;

    psn_front #(.W(W)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_pts   ({i_query_x, i_query_y, i_start_x, i_start_y, i_end_x, i_end_y}),
        .o_valid (fr_valid),
        .i_ready (fr_ready),
        .o_pts   (fr_pts),
        .o_code  (fr_code),
        .o_sx    (fr_sx),
        .o_sy    (fr_sy),
        .o_mx    (fr_mx),
        .o_my    (fr_my),
        .o_num   (fr_num),
        .o_den   (fr_den)
    );

    psn_mul #(.W(W), .SIDE_W(SIDE_M)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (fr_ready),
        .i_mx    (fr_mx),
        .i_my    (fr_my),
        .i_num   (fr_num),
        .i_side  ({fr_den, fr_code, fr_sx, fr_sy, fr_pts}),
        .o_valid (mu_valid),
        .i_ready (mu_ready),
        .o_nx    (mu_nx),
        .o_ny    (mu_ny),
        .o_side  (mu_side)
    );

    psn_div #(.W(W), .SIDE_W(SIDE_D)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mu_valid),
        .o_ready (mu_ready),
        .i_nx    (mu_nx),
        .i_ny    (mu_ny),
        .i_den   (mu_side[SIDE_M-1:SIDE_D]),
        .i_side  (mu_side[SIDE_D-1:0]),
        .o_valid (dv_valid),
        .i_ready (dv_ready),
        .o_qx    (dv_qx),
        .o_qy    (dv_qy),
        .o_side  (dv_side)
    );

    // Output stage: pick the foot and form the displacement.
    logic                r_out_vld;
    logic signed [W:0]   r_disp_x, r_disp_y;
    logic [W-1:0]        r_foot_x, r_foot_y;
    logic [1:0]          r_where;

    psn_pkg::t_where     code;
    logic                sx, sy;
    logic [W-1:0]        px, py, ax, ay, bx, by;
    logic [W:0]          n_fx, n_fy;

    assign code = psn_pkg::t_where'(dv_side[SIDE_D-1:SIDE_D-psn_pkg::WHERE_W]);
    assign sx   = dv_side[6*W+1];
    assign sy   = dv_side[6*W];
    assign px   = dv_side[6*W-1:5*W];
    assign py   = dv_side[5*W-1:4*W];
    assign ax   = dv_side[4*W-1:3*W];
    assign ay   = dv_side[3*W-1:2*W];
    assign bx   = dv_side[2*W-1:W];
    assign by   = dv_side[W-1:0];

    always_comb begin
        unique case (code)
            psn_pkg::WHERE_INSIDE: begin
                n_fx = sx ? {ax[W-1], ax} - {1'b0, dv_qx} : {ax[W-1], ax} + {1'b0, dv_qx};
                n_fy = sy ? {ay[W-1], ay} - {1'b0, dv_qy} : {ay[W-1], ay} + {1'b0, dv_qy};
            end
            psn_pkg::WHERE_END: begin
                n_fx = {bx[W-1], bx};
                n_fy = {by[W-1], by};
            end
            default: begin
                n_fx = {ax[W-1], ax};
                n_fy = {ay[W-1], ay};
            end
        endcase
    end

    assign dv_ready = !r_out_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (dv_ready) begin
            r_out_vld <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dv_ready) begin
            r_foot_x <= n_fx[W-1:0];
            r_foot_y <= n_fy[W-1:0];
            r_disp_x <= n_fx - {px[W-1], px};
            r_disp_y <= n_fy - {py[W-1], py};
            r_where  <= code;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_disp_x     = r_disp_x;
    assign o_disp_y     = r_disp_y;
    assign o_foot_x     = r_foot_x;
    assign o_foot_y     = r_foot_y;
    assign o_where_code = r_where;

endmodule

// ----- hw/rtl/psn_front.sv -----
// Differences, products, dot product and squared length, then classification.
module psn_front #(
    parameter int W = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [6*W-1:0]      i_pts,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [6*W-1:0]      o_pts,
    output psn_pkg::t_where     o_code,
    output logic                o_sx,
    output logic                o_sy,
    output logic [W-1:0]        o_mx,
    output logic [W-1:0]        o_my,
    output logic [2*W:0]        o_num,
    output logic [2*W:0]        o_den
);

    localparam int NS = 4;

    logic [NS-1:0]        r_vld;
    logic [NS-1:0]        rdy;
    logic [6*W-1:0]       r_pts [NS];

    logic signed [W:0]    r_dx, r_dy, r_ux, r_uy;
    logic signed [2*W+1:0] r_pxx, r_pyy, r_pux, r_puy;
    logic [W-1:0]         r_mx1, r_my1, r_mx2, r_my2, r_mx3, r_my3;
    logic                 r_sx1, r_sy1, r_sx2, r_sy2, r_sx3, r_sy3;
    logic signed [2*W+1:0] r_len2, r_dot;
    psn_pkg::t_where      r_code;
    logic [2*W:0]         r_num, r_den;

    logic signed [W-1:0]  px, py, ax, ay, bx, by;
    psn_pkg::t_where      n_code;

    assign px = i_pts[6*W-1:5*W];
    assign py = i_pts[5*W-1:4*W];
    assign ax = i_pts[4*W-1:3*W];
    assign ay = i_pts[3*W-1:2*W];
    assign bx = i_pts[2*W-1:W];
    assign by = i_pts[W-1:0];

    always_comb begin
        rdy[NS-1] = !r_vld[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_comb begin
        if (r_len2 == '0) begin
            n_code = psn_pkg::WHERE_DEGEN;
        end else if (r_dot[2*W+1]) begin
            n_code = psn_pkg::WHERE_START;
        end else if (r_dot > r_len2) begin
            n_code = psn_pkg::WHERE_END;
        end else begin
            n_code = psn_pkg::WHERE_INSIDE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_pts[0] <= i_pts;
            r_dx <= {bx[W-1], bx} - {ax[W-1], ax};
            r_dy <= {by[W-1], by} - {ay[W-1], ay};
            r_ux <= {px[W-1], px} - {ax[W-1], ax};
            r_uy <= {py[W-1], py} - {ay[W-1], ay};
        end
        if (rdy[1]) begin
            r_pts[1] <= r_pts[0];
            r_pxx <= r_dx * r_dx;
            r_pyy <= r_dy * r_dy;
            r_pux <= r_ux * r_dx;
            r_puy <= r_uy * r_dy;
            r_sx1 <= r_dx[W];
            r_sy1 <= r_dy[W];
            r_mx1 <= r_dx[W] ? W'(-r_dx) : r_dx[W-1:0];
            r_my1 <= r_dy[W] ? W'(-r_dy) : r_dy[W-1:0];
        end
        if (rdy[2]) begin
            r_pts[2] <= r_pts[1];
            r_len2 <= r_pxx + r_pyy;
            r_dot  <= r_pux + r_puy;
            r_sx2 <= r_sx1;
            r_sy2 <= r_sy1;
            r_mx2 <= r_mx1;
            r_my2 <= r_my1;
        end
        if (rdy[3]) begin
            r_pts[3] <= r_pts[2];
            r_code <= n_code;
            r_num  <= (n_code == psn_pkg::WHERE_INSIDE) ? r_dot[2*W:0] : '0;
            r_den  <= r_len2[2*W:0];
            r_sx3 <= r_sx2;
            r_sy3 <= r_sy2;
            r_mx3 <= r_mx2;
            r_my3 <= r_my2;
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_vld[NS-1];
    assign o_pts   = r_pts[NS-1];
    assign o_code  = r_code;
    assign o_sx    = r_sx3;
    assign o_sy    = r_sy3;
    assign o_mx    = r_mx3;
    assign o_my    = r_my3;
    assign o_num   = r_num;
    assign o_den   = r_den;

`ifndef SYNTHESIS
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted transaction did not enter the first stage");
    a_num_le_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NS-1] && r_code == psn_pkg::WHERE_INSIDE) |-> (r_num <= r_den))
        else $error("inside foot with dot product above squared length");
`endif

endmodule

// ----- hw/rtl/psn_mul.sv -----
// Scales both offset magnitudes by the dot product in two half-width products.
module psn_mul #(
    parameter int W      = 24,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [W-1:0]      i_mx,
    input  logic [W-1:0]      i_my,
    input  logic [2*W:0]      i_num,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [3*W:0]      o_nx,
    output logic [3*W:0]      o_ny,
    output logic [SIDE_W-1:0] o_side
);

    localparam int NS = 2;

    logic [NS-1:0]     r_vld;
    logic [NS-1:0]     rdy;
    logic [SIDE_W-1:0] r_side [NS];
    logic [2*W-1:0]    r_plx, r_ply;
    logic [2*W:0]      r_phx, r_phy;
    logic [3*W:0]      r_nx, r_ny;

    always_comb begin
        rdy[1] = !r_vld[1] || i_ready;
        rdy[0] = !r_vld[0] || rdy[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) r_vld[0] <= i_valid;
            if (rdy[1]) r_vld[1] <= r_vld[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_side[0] <= i_side;
            r_plx <= i_mx * i_num[W-1:0];
            r_ply <= i_my * i_num[W-1:0];
            r_phx <= i_mx * i_num[2*W:W];
            r_phy <= i_my * i_num[2*W:W];
        end
        if (rdy[1]) begin
            r_side[1] <= r_side[0];
            r_nx <= {r_phx, {W{1'b0}}} + (3*W+1)'(r_plx);
            r_ny <= {r_phy, {W{1'b0}}} + (3*W+1)'(r_ply);
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_vld[NS-1];
    assign o_nx    = r_nx;
    assign o_ny    = r_ny;
    assign o_side  = r_side[NS-1];

endmodule

// ----- hw/rtl/psn_div.sv -----
// Restoring division, one quotient bit per stage for each axis.
module psn_div #(
    parameter int W      = 24,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [3*W:0]      i_nx,
    input  logic [3*W:0]      i_ny,
    input  logic [2*W:0]      i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [W-1:0]      o_qx,
    output logic [W-1:0]      o_qy,
    output logic [SIDE_W-1:0] o_side
);

    localparam int NS = W;

    logic [NS-1:0]     r_vld;
    logic [NS-1:0]     rdy;
    logic [2*W:0]      r_rx [NS];
    logic [2*W:0]      r_ry [NS];
    logic [2*W:0]      r_den [NS];
    logic [W-1:0]      r_lx [NS];
    logic [W-1:0]      r_ly [NS];
    logic [W-1:0]      r_qx [NS];
    logic [W-1:0]      r_qy [NS];
    logic [SIDE_W-1:0] r_side [NS];

    always_comb begin
        rdy[NS-1] = !r_vld[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // The upper part of the numerator is already below the divisor, so only
    // the low W bits are brought down, one per stage.
    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic [2*W:0]      s_rx, s_ry, s_den;
        logic [W-1:0]      s_lx, s_ly, s_qx, s_qy;
        logic [SIDE_W-1:0] s_side;
        logic [2*W+1:0]    w_tx, w_ty;
        logic              w_gex, w_gey;

        if (k == 0) begin : g_first
            assign s_rx   = i_nx[3*W:W];
            assign s_ry   = i_ny[3*W:W];
            assign s_lx   = i_nx[W-1:0];
            assign s_ly   = i_ny[W-1:0];
            assign s_qx   = '0;
            assign s_qy   = '0;
            assign s_den  = i_den;
            assign s_side = i_side;
        end else begin : g_next
            assign s_rx   = r_rx[k-1];
            assign s_ry   = r_ry[k-1];
            assign s_lx   = r_lx[k-1];
            assign s_ly   = r_ly[k-1];
            assign s_qx   = r_qx[k-1];
            assign s_qy   = r_qy[k-1];
            assign s_den  = r_den[k-1];
            assign s_side = r_side[k-1];
        end

        assign w_tx  = {s_rx, s_lx[W-1]};
        assign w_ty  = {s_ry, s_ly[W-1]};
        assign w_gex = (w_tx >= {1'b0, s_den});
        assign w_gey = (w_ty >= {1'b0, s_den});

        always_ff @(posedge i_clk) begin
            if (rdy[k]) begin
                r_rx[k]   <= w_gex ? (2*W+1)'(w_tx - {1'b0, s_den}) : w_tx[2*W:0];
                r_ry[k]   <= w_gey ? (2*W+1)'(w_ty - {1'b0, s_den}) : w_ty[2*W:0];
                r_lx[k]   <= {s_lx[W-2:0], 1'b0};
                r_ly[k]   <= {s_ly[W-2:0], 1'b0};
                r_qx[k]   <= {s_qx[W-2:0], w_gex};
                r_qy[k]   <= {s_qy[W-2:0], w_gey};
                r_den[k]  <= s_den;
                r_side[k] <= s_side;
            end
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_vld[NS-1];
    assign o_qx    = r_qx[NS-1];
    assign o_qy    = r_qy[NS-1];
    assign o_side  = r_side[NS-1];

`ifndef SYNTHESIS
    a_rem_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NS-1] && r_den[NS-1] != '0) |-> (r_rx[NS-1] < r_den[NS-1]))
        else $error("x remainder not below divisor");
    a_rem_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NS-1] && r_den[NS-1] != '0) |-> (r_ry[NS-1] < r_den[NS-1]))
        else $error("y remainder not below divisor");
`endif

endmodule
